// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent check that is switched off while reset is held.
`define CHK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Concurrent check that is also evaluated during reset.
`define CHK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== src/lfws_pkg.sv =====
`default_nettype none
package lfws_pkg;

  localparam logic [1:0] CMD_MEAS = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_ACT  = 2'd2;

  localparam logic [7:0] ACT_BWD = 8'd3;
  localparam logic [7:0] ACT_FWD = 8'd4;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BWD  = 2'd2;

  localparam logic [2:0] REG_SPEED_MAX   = 3'd0;
  localparam logic [2:0] REG_STEER_GAIN  = 3'd1;
  localparam logic [2:0] REG_SENSOR_OFF  = 3'd2;
  localparam logic [2:0] REG_WHEEL_SCALE = 3'd3;
  localparam logic [2:0] REG_WHEEL_MAX   = 3'd4;
  localparam logic [2:0] REG_WHEEL_MIN   = 3'd5;
  localparam logic [2:0] REG_TRAVEL_DIR  = 3'd6;
  localparam logic [2:0] REG_INIT_TARGET = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0] LINE_GOOD_MASK   = 8'b0000_0001;
  localparam logic [7:0] TRACK_LEVEL_MASK = 8'b0000_1110;
  localparam logic [6:0] SLOW_PCT = 7'd35;
  localparam logic [6:0] FULL_PCT = 7'd100;

  // Length of the shared iteration loop, in steps. The 24-bit product
  // |speed_max| * percent is held here while the loop runs.
  localparam int DIV_BITS = 24;
  localparam int CNT_W    = 5;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_BITS - 1);
  // Division by 100 is a multiply by ceil(2^29 / 100) and a shift by 29. The
  // quotient is exact for every dividend below 2^29 / 88, far above 100 * 2^15.
  localparam logic [22:0] PCT_RECIP = 23'd5368710;
  localparam int PCT_SHIFT = 29;

  typedef enum logic [1:0] {
    MUL_VS = 2'd0,
    MUL_GA = 2'd1,
    MUL_L  = 2'd2,
    MUL_R  = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic             meas_load;
    logic             act_load;
    logic             cordic_en;
    logic             div_en;
    logic [CNT_W-1:0] iter_idx;
    mul_sel_t         mul_sel;
    logic             vs_load;
    logic             fac_load;
    logic             left_store;
    logic             right_store;
    logic             emit;
  } cmd_t;

  typedef struct packed {
    logic gate;
    logic out_free;
  } stat_t;

  // atan(2^-i) in Q2.14, rounded to nearest.
  function automatic logic [13:0] atan_q14(input logic [CNT_W-1:0] i);
    logic [13:0] r;
    case (i)
      5'd0:  r = 14'd12868;
      5'd1:  r = 14'd7596;
      5'd2:  r = 14'd4014;
      5'd3:  r = 14'd2037;
      5'd4:  r = 14'd1023;
      5'd5:  r = 14'd512;
      5'd6:  r = 14'd256;
      5'd7:  r = 14'd128;
      5'd8:  r = 14'd64;
      5'd9:  r = 14'd32;
      5'd10: r = 14'd16;
      5'd11: r = 14'd8;
      5'd12: r = 14'd4;
      5'd13: r = 14'd2;
      5'd14: r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/lfws_ctrl.sv =====
`default_nettype none
module lfws_ctrl #(
  parameter int ANGLE_ITERS = 14
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  input  wire logic [1:0]      in_cmd,
  output logic                 in_tready,
  output lfws_pkg::cmd_t       cmd,
  input  wire lfws_pkg::stat_t stat
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_ITER = 9'b000000010,
    ST_MVS  = 9'b000000100,
    ST_MGA  = 9'b000001000,
    ST_FAC  = 9'b000010000,
    ST_ML   = 9'b000100000,
    ST_MR   = 9'b001000000,
    ST_FIN  = 9'b010000000,
    ST_EMIT = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [lfws_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.mul_sel  = lfws_pkg::MUL_VS;
    cmd.iter_idx = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cmd.meas_load = accept && (in_cmd == lfws_pkg::CMD_MEAS);
        cmd.act_load  = accept && (in_cmd == lfws_pkg::CMD_ACT);
        if (accept && (in_cmd == lfws_pkg::CMD_MEAS)) begin
          state_nxt = ST_ITER;
          cnt_nxt   = '0;
        end else if (accept && (in_cmd == lfws_pkg::CMD_TICK)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_ITER: begin
        cmd.div_en    = 1'b1;
        cmd.cordic_en = ({27'd0, cnt_r} < 32'(ANGLE_ITERS));
        if (cnt_r == lfws_pkg::LAST_STEP) begin
          state_nxt = ST_MVS;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_MVS: begin
        cmd.mul_sel = lfws_pkg::MUL_VS;
        state_nxt   = ST_MGA;
      end
      ST_MGA: begin
        cmd.mul_sel = lfws_pkg::MUL_GA;
        cmd.vs_load = 1'b1;
        state_nxt   = ST_FAC;
      end
      ST_FAC: begin
        cmd.fac_load = 1'b1;
        state_nxt    = ST_ML;
      end
      ST_ML: begin
        cmd.mul_sel = lfws_pkg::MUL_L;
        state_nxt   = ST_MR;
      end
      ST_MR: begin
        cmd.mul_sel    = lfws_pkg::MUL_R;
        cmd.left_store = 1'b1;
        state_nxt      = ST_FIN;
      end
      ST_FIN: begin
        cmd.right_store = 1'b1;
        state_nxt       = ST_IDLE;
      end
      ST_EMIT: begin
        cmd.emit = stat.gate && stat.out_free;
        if (!stat.gate || stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/lfws_dp.sv =====
`default_nettype none
module lfws_dp #(
  parameter int POS_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [lfws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lfws_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic [((16+3*POS_WIDTH+7)/8)*8-1:0] in_tdata,
  input  wire lfws_pkg::cmd_t                    cmd,
  output lfws_pkg::stat_t                        stat,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [31:0]                            out_tdata,
  output logic [1:0]                             out_tuser
);

  localparam int PW_EFF = (POS_WIDTH > 17) ? POS_WIDTH : 17;
  localparam int CW     = PW_EFF + 17;

  // Configuration.
  logic signed [15:0] speed_max_r;
  logic [15:0] steer_gain_r, sensor_off_r, wheel_scale_r;
  logic [14:0] wheel_max_r, wheel_min_r;
  logic        travel_dir_r;

  // Block state.
  logic [6:0]  speed_pct_r, target_pct_r;
  logic [14:0] left_r, right_r;
  logic        line_ok_r;
  logic [2:0]  level_r;
  logic [1:0]  cmd_dir_r;

  // Input fields.
  logic [7:0]                  st_byte;
  logic signed [POS_WIDTH-1:0] lat, zone_a, zone_c;
  logic [7:0]                  act_code;

  assign st_byte  = in_tdata[7:0];
  assign lat      = in_tdata[8 +: POS_WIDTH];
  assign zone_a   = in_tdata[8+POS_WIDTH +: POS_WIDTH];
  assign zone_c   = in_tdata[8+2*POS_WIDTH +: POS_WIDTH];
  assign act_code = in_tdata[8+3*POS_WIDTH +: 8];

  logic [1:0] dir_code;
  assign dir_code = travel_dir_r ? lfws_pkg::DIR_BWD : lfws_pkg::DIR_FWD;

  // Speed magnitude times percent, divided by 100 through a reciprocal multiply.
  logic signed [16:0] sm_ext;
  logic [16:0]        vmag;
  logic [lfws_pkg::DIV_BITS-1:0] div_n_r;
  logic [16:0] q_r;
  logic [46:0] q_prod;

  assign sm_ext = 17'(speed_max_r);
  assign vmag   = sm_ext[16] ? 17'(-sm_ext) : 17'(sm_ext);
  assign q_prod = {23'd0, div_n_r} * {24'd0, lfws_pkg::PCT_RECIP};

  // Vectoring CORDIC.
  logic signed [CW-1:0] x_r, y_r;
  logic signed [16:0]   z_r;
  logic signed [CW-1:0] xs, ys;
  logic signed [16:0]   atn;

  assign xs  = x_r >>> cmd.iter_idx;
  assign ys  = y_r >>> cmd.iter_idx;
  assign atn = 17'($signed({3'b000, lfws_pkg::atan_q14(cmd.iter_idx)}));

  // Shared multiplier.
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] p_r;
  logic [31:0]        vs_r;
  logic signed [32:0] fac_l_r, fac_r_r;
  logic signed [33:0] prod, fl, fr;

  always_comb begin
    case (cmd.mul_sel)
      lfws_pkg::MUL_VS: begin
        mul_a = $signed({16'd0, q_r});
        mul_b = $signed({17'd0, wheel_scale_r});
      end
      lfws_pkg::MUL_GA: begin
        mul_a = $signed({17'd0, steer_gain_r});
        mul_b = 33'(z_r);
      end
      lfws_pkg::MUL_L: begin
        mul_a = fac_l_r;
        mul_b = $signed({1'b0, vs_r});
      end
      lfws_pkg::MUL_R: begin
        mul_a = fac_r_r;
        mul_b = $signed({1'b0, vs_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 34'($signed(p_r[32:0]));
  assign fl   = 34'sd67108864 - prod;
  assign fr   = 34'sd67108864 + prod;

  // Clip a product to wheel_max, then drop it to zero below wheel_min.
  function automatic logic [14:0] clip_speed(input logic [31:0] w,
                                             input logic [14:0] wmax,
                                             input logic [14:0] wmin);
    logic [14:0] c;
    c = (w > {17'd0, wmax}) ? wmax : w[14:0];
    return (c < wmin) ? 15'd0 : c;
  endfunction

  // Tick gate and output values.
  logic        sgn_ok;
  logic [6:0]  pct_nxt;
  logic signed [15:0] l_val, r_val, l_mag, r_mag;
  logic        trk_low;

  assign sgn_ok = travel_dir_r ? speed_max_r[15]
                               : (!speed_max_r[15] && (speed_max_r != 16'sd0));
  assign stat.gate     = sgn_ok && (cmd_dir_r == dir_code);
  assign stat.out_free = !out_tvalid || out_tready;

  assign pct_nxt = (target_pct_r > speed_pct_r) ? speed_pct_r + 7'd1 :
                   (target_pct_r < speed_pct_r) ? speed_pct_r - 7'd1 : speed_pct_r;
  assign l_mag = $signed({1'b0, left_r});
  assign r_mag = $signed({1'b0, right_r});
  assign l_val = !line_ok_r ? 16'sd0 : (travel_dir_r ? -l_mag : l_mag);
  assign r_val = !line_ok_r ? 16'sd0 : (travel_dir_r ? r_mag : -r_mag);
  assign trk_low = line_ok_r && (level_r != 3'd0) && (level_r <= 3'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_max_r   <= '0;
      steer_gain_r  <= 16'd4096;
      sensor_off_r  <= 16'd1000;
      wheel_scale_r <= 16'd256;
      wheel_max_r   <= 15'd32767;
      wheel_min_r   <= '0;
      travel_dir_r  <= 1'b0;
      speed_pct_r   <= '0;
      target_pct_r  <= '0;
      left_r        <= '0;
      right_r       <= '0;
      line_ok_r     <= 1'b0;
      level_r       <= '0;
      cmd_dir_r     <= lfws_pkg::DIR_NONE;
      out_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lfws_pkg::REG_SPEED_MAX:   speed_max_r   <= $signed(cfg_wdata);
          lfws_pkg::REG_STEER_GAIN:  steer_gain_r  <= cfg_wdata;
          lfws_pkg::REG_SENSOR_OFF:  sensor_off_r  <= cfg_wdata;
          lfws_pkg::REG_WHEEL_SCALE: wheel_scale_r <= cfg_wdata;
          lfws_pkg::REG_WHEEL_MAX:   wheel_max_r   <= cfg_wdata[14:0];
          lfws_pkg::REG_WHEEL_MIN:   wheel_min_r   <= cfg_wdata[14:0];
          lfws_pkg::REG_TRAVEL_DIR:  travel_dir_r  <= cfg_wdata[0];
          lfws_pkg::REG_INIT_TARGET: begin
            target_pct_r <= (cfg_wdata[6:0] > lfws_pkg::FULL_PCT) ?
                            lfws_pkg::FULL_PCT : cfg_wdata[6:0];
          end
          default: begin
          end
        endcase
      end
      if (cmd.meas_load) begin
        line_ok_r <= st_byte[0] & lfws_pkg::LINE_GOOD_MASK[0];
        level_r   <= 3'((st_byte & lfws_pkg::TRACK_LEVEL_MASK) >> 1);
        if (cmd_dir_r == dir_code) begin
          if (!st_byte[0]) begin
            target_pct_r <= '0;
          end else if (zone_c > 0) begin
            target_pct_r <= '0;
          end else if (zone_a == 0) begin
            target_pct_r <= lfws_pkg::FULL_PCT;
          end else if (zone_a < 0) begin
            target_pct_r <= lfws_pkg::SLOW_PCT;
          end
        end
      end
      if (cmd.act_load) begin
        if (act_code == lfws_pkg::ACT_BWD) begin
          cmd_dir_r <= lfws_pkg::DIR_BWD;
        end else if (act_code == lfws_pkg::ACT_FWD) begin
          cmd_dir_r <= lfws_pkg::DIR_FWD;
        end
      end
      if (cmd.left_store) begin
        left_r <= clip_speed(32'(p_r[65:34]), wheel_max_r, wheel_min_r);
      end
      if (cmd.right_store) begin
        right_r <= clip_speed(32'(p_r[65:34]), wheel_max_r, wheel_min_r);
      end
      if (cmd.emit) begin
        speed_pct_r <= pct_nxt;
        out_tvalid  <= 1'b1;
      end else if (out_tready) begin
        out_tvalid  <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
    if (cmd.meas_load) begin
      div_n_r <= lfws_pkg::DIV_BITS'(vmag * speed_pct_r);
      q_r     <= '0;
      x_r     <= $signed(CW'({sensor_off_r, 14'd0}));
      y_r     <= CW'(lat) <<< 14;
      z_r     <= '0;
    end else begin
      if (cmd.div_en) begin
        q_r <= q_prod[lfws_pkg::PCT_SHIFT +: 17];
      end
      if (cmd.cordic_en) begin
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atn;
        end else if (y_r < 0) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atn;
        end
      end
    end
    if (cmd.vs_load) begin
      vs_r <= p_r[31:0];
    end
    if (cmd.fac_load) begin
      fac_l_r <= (fl > 0) ? fl[32:0] : 33'sd0;
      fac_r_r <= (fr > 0) ? fr[32:0] : 33'sd0;
    end
    if (cmd.emit) begin
      out_tdata <= {r_val, l_val};
      out_tuser <= {trk_low, !line_ok_r};
    end
  end

endmodule
`default_nettype wire

// ===== src/line_follow_wheel_speed_core.sv =====
`default_nettype none
// Steering core for a two-wheel vehicle following a magnetic line. Each beat
// on the input carries a kind in in_tuser: a measurement recomputes both wheel
// speeds from the heading error atan(lateral/sensor_offset), a ramp tick moves
// the speed percent one step toward its target and returns one beat with the
// signed wheel commands (or nothing when the direction gate is closed), and an
// action sets the commanded direction. Action and ignored kinds keep the core
// idle; a tick waits while the gate is open and the output register is full.
// A measurement runs 24 steps of the shared iteration loop, where the CORDIC
// arctangent runs while the divide by 100 is done as a multiply by a scaled
// reciprocal, then six steps through the single shared multiplier. The user
// must write configuration only while the core is idle; no check enforces it.
module line_follow_wheel_speed_core #(
  parameter int POS_WIDTH   = 16,
  parameter int ANGLE_ITERS = 14
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [lfws_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lfws_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // status_byte, pos_lateral, pos_zone_a, pos_zone_c, action_code
  input  wire logic [((16+3*POS_WIDTH+7)/8)*8-1:0] in_tdata,
  // cmd
  input  wire logic [1:0]                          in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // wheel_left, right_cmd
  output logic [31:0]                              out_tdata,
  // line_lost, track_weak
  output logic [1:0]                               out_tuser
);

  lfws_pkg::cmd_t  cmd;
  lfws_pkg::stat_t stat;

  // The sequencer owns the iteration count and the order of multiplier use.
  lfws_ctrl #(.ANGLE_ITERS(ANGLE_ITERS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath holds configuration, vehicle state and the output register.
  lfws_dp #(.POS_WIDTH(POS_WIDTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// ===== src/lfws_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module lfws_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  `CHK_ALWAYS(a_rst_clears, clk, !rst_n |=> !out_tvalid, "out valid after reset")
  `CHK_RST(a_hold_valid, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "beat dropped")
  `CHK_RST(a_hold_data, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata), "data moved")
  `CHK_RST(a_lost_zero, clk, rst_n, out_tvalid && out_tuser[0] |-> out_tdata == 32'd0, "lost not zero")
  `CHK_RST(a_lost_low, clk, rst_n, out_tvalid && out_tuser[0] |-> !out_tuser[1], "low level when lost")

endmodule

bind line_follow_wheel_speed_core lfws_checker u_lfws_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

// ===== bench/line_follow_wheel_speed_core_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
// Testbench for the line-follower wheel speed core.
//
// The input channel carries one beat per command: the kind in in_tuser and
// the measurement or action fields packed in in_tdata. A behavioral copy of
// the steering math runs in this module. Every accepted input beat updates
// that copy, and every tick that passes the direction gate adds one expected
// wheel command to a queue. A checker process compares each output beat,
// field by field, against the oldest queued command.
//
// The run starts with a directed set of corner items and then goes through
// several random phases under changing register settings. Before it writes
// registers, the bench drains all expected results and waits out the
// measurement latency, because a measurement returns no beat.
module line_follow_wheel_speed_core_test;

  localparam int ITERS        = 14;
  localparam int MEAS_LATENCY = 40;  // covers a measurement still in flight
  localparam int HOLD_CYCLES  = 400;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // atan(2^-i) in Q2.14.
  localparam longint ARCTAN_Q14 [0:14] = '{12868, 7596, 4014, 2037, 1023, 512, 256,
                                           128, 64, 32, 16, 8, 4, 2, 1};

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic        lost;
    logic        trk_low;
  } wheel_cmd_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [lfws_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lfws_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [63:0]                     in_tdata = '0;
  logic [1:0]                      in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [31:0]                     out_tdata;
  logic [1:0]                      out_tuser;

  line_follow_wheel_speed_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #1 clk = ~clk;

  // Register copies used by the predictor.
  logic signed [15:0] m_speed_max;
  logic [15:0]        m_gain, m_offset, m_scale;
  logic [14:0]        m_wmax, m_wmin;
  logic               m_dir;
  // State copies.
  logic [6:0]         m_speed_pct, m_target_pct;
  logic [15:0]        m_left, m_right;
  logic               m_line_ok;
  logic [2:0]         m_level;
  logic [1:0]         m_cmd_dir;

  wheel_cmd_t wheel_cmds_due[$];
  int         fail_count = 0;
  int         beats_checked = 0;
  int         items_sent = 0;
  int         hold_requests = 0; // raised by the stimulus to start a hold-off
  int         hold_seen = 0;     // requests already taken up by the receiver
  int         hold_left = 0;     // receiver hold-off, counted down per cycle
  bit         steady = 1'b0;     // when set neither side idles at random

  // Heading angle in Q2.14 by vectoring CORDIC.
  function automatic longint heading_q14(longint lat, longint off);
    longint x, y, z, nx, ny;
    x = off * 16384;
    y = lat * 16384;
    z = 0;
    for (int i = 0; i < ITERS; i++) begin
      nx = x;
      ny = y;
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += ARCTAN_Q14[i];
      end else if (y < 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= ARCTAN_Q14[i];
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic logic [15:0] clip_wheel(longint factor, longint unsigned v);
    longint unsigned w;
    w = 0;
    if (factor > 0) w = (longint'(factor) * v * longint'(m_scale)) >> 34;
    if (w > m_wmax) w = m_wmax;
    if (w < m_wmin) w = 0;
    return w[15:0];
  endfunction

  function automatic logic [1:0] cfg_dir_code();
    return m_dir ? lfws_pkg::DIR_BWD : lfws_pkg::DIR_FWD;
  endfunction

  // Advances the steering state by one accepted beat.
  task automatic predict_steering(logic [1:0] kind, logic [63:0] data);
    logic [7:0]     st;
    longint         lat, za, zc, ang, prod, sgn, d, l, r;
    longint unsigned vmag, v;
    wheel_cmd_t     c;
    st  = data[7:0];
    lat = longint'($signed(data[23:8]));
    za  = longint'($signed(data[39:24]));
    zc  = longint'($signed(data[55:40]));
    if (kind == lfws_pkg::CMD_MEAS) begin
      m_line_ok = st[0];
      m_level = st[3:1];
      if (m_cmd_dir == cfg_dir_code()) begin
        if (!m_line_ok) m_target_pct = '0;
        else if (zc > 0) m_target_pct = '0;
        else if (za == 0) m_target_pct = lfws_pkg::FULL_PCT;
        else if (za < 0) m_target_pct = lfws_pkg::SLOW_PCT;
      end
      vmag = (m_speed_max < 0) ? -longint'(m_speed_max) : longint'(m_speed_max);
      v = vmag * m_speed_pct / 100;
      ang = heading_q14(lat, longint'(m_offset));
      prod = longint'(m_gain) * ang;
      m_left = clip_wheel((longint'(1) << 26) - prod, v);
      m_right = clip_wheel((longint'(1) << 26) + prod, v);
    end else if (kind == lfws_pkg::CMD_TICK) begin
      sgn = (m_speed_max > 0) ? 1 : ((m_speed_max < 0) ? -1 : 0);
      d = m_dir ? -1 : 1;
      if (sgn == d && m_cmd_dir == cfg_dir_code()) begin
        if (m_target_pct > m_speed_pct) m_speed_pct++;
        else if (m_target_pct < m_speed_pct) m_speed_pct--;
        l = m_line_ok ? longint'(m_left) * d : 0;
        r = m_line_ok ? -longint'(m_right) * d : 0;
        c.left = l[15:0];
        c.right = r[15:0];
        c.lost = ~m_line_ok;
        c.trk_low = m_line_ok && m_level >= 3'd1 && m_level <= 3'd3;
        wheel_cmds_due.push_back(c);
      end
    end else if (kind == lfws_pkg::CMD_ACT) begin
      if (data[63:56] == lfws_pkg::ACT_BWD) m_cmd_dir = lfws_pkg::DIR_BWD;
      else if (data[63:56] == lfws_pkg::ACT_FWD) m_cmd_dir = lfws_pkg::DIR_FWD;
    end
  endtask

  function automatic logic [63:0] pack_fields(logic [7:0] st, logic [15:0] lat,
                                              logic [15:0] za, logic [15:0] zc,
                                              logic [7:0] act);
    return {act, zc, za, lat, st};
  endfunction

  // Offers one beat, idling first at random, and predicts it once accepted.
  task automatic send_beat(logic [1:0] kind, logic [63:0] data);
    if (!steady && $urandom_range(0, 99) < 34) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_steering(kind, data);
    items_sent++;
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Writes a register into the core and into the predictor copy.
  task automatic write_reg(logic [lfws_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      lfws_pkg::REG_SPEED_MAX:   m_speed_max = val;
      lfws_pkg::REG_STEER_GAIN:  m_gain = val;
      lfws_pkg::REG_SENSOR_OFF:  m_offset = val;
      lfws_pkg::REG_WHEEL_SCALE: m_scale = val;
      lfws_pkg::REG_WHEEL_MAX:   m_wmax = val[14:0];
      lfws_pkg::REG_WHEEL_MIN:   m_wmin = val[14:0];
      lfws_pkg::REG_TRAVEL_DIR:  m_dir = val[0];
      lfws_pkg::REG_INIT_TARGET: begin
        m_target_pct = (val[6:0] > lfws_pkg::FULL_PCT) ? lfws_pkg::FULL_PCT : val[6:0];
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits for every expected beat, then for a measurement still in flight.
  task automatic drain_core();
    end_burst();
    while (wheel_cmds_due.size() != 0) @(posedge clk);
    repeat (MEAS_LATENCY) @(posedge clk);
  endtask

  task automatic load_setting(logic [15:0] smax, logic [15:0] gain, logic [15:0] off,
                              logic [15:0] scale, logic [15:0] wmax, logic [15:0] wmin,
                              logic dir, logic [15:0] target);
    drain_core();
    write_reg(lfws_pkg::REG_SPEED_MAX, smax);
    write_reg(lfws_pkg::REG_STEER_GAIN, gain);
    write_reg(lfws_pkg::REG_SENSOR_OFF, off);
    write_reg(lfws_pkg::REG_WHEEL_SCALE, scale);
    write_reg(lfws_pkg::REG_WHEEL_MAX, wmax);
    write_reg(lfws_pkg::REG_WHEEL_MIN, wmin);
    write_reg(lfws_pkg::REG_TRAVEL_DIR, {15'd0, dir});
    write_reg(lfws_pkg::REG_INIT_TARGET, target);
  endtask

  // Mostly well-formed traffic: measurements and ticks, with actions that
  // usually pick a legal direction, plus a few ignored kinds.
  task automatic random_beat();
    int          r;
    logic [7:0]  st, act;
    logic [15:0] lat, za, zc;
    r = $urandom_range(0, 99);
    st = 8'($urandom);
    if ($urandom_range(0, 99) < 80) st[0] = 1'b1;
    lat = ($urandom_range(0, 1) == 0) ? 16'($signed($urandom_range(0, 4000)) - 2000)
                                      : 16'($urandom);
    case ($urandom_range(0, 2))
      0: za = 16'd0;
      1: za = 16'h8000 | 16'($urandom);
      default: za = 16'h7fff & 16'($urandom);
    endcase
    zc = ($urandom_range(0, 99) < 80) ? (16'h8000 | 16'($urandom))
                                      : (16'h7fff & 16'($urandom));
    if ($urandom_range(0, 3) == 0) zc = 16'd0;
    act = ($urandom_range(0, 99) < 70) ? (m_dir ? lfws_pkg::ACT_BWD : lfws_pkg::ACT_FWD)
                                       : 8'($urandom);
    if (r < 40) send_beat(lfws_pkg::CMD_MEAS, pack_fields(st, lat, za, zc, act));
    else if (r < 88) send_beat(lfws_pkg::CMD_TICK, pack_fields(st, lat, za, zc, act));
    else if (r < 96) send_beat(lfws_pkg::CMD_ACT, pack_fields(st, lat, za, zc, act));
    else send_beat(CMD_UNUSED, pack_fields(st, lat, za, zc, act));
  endtask

  task automatic random_phase(int count);
    send_beat(lfws_pkg::CMD_ACT, pack_fields(8'd0, 16'd0, 16'd0, 16'd0,
                                             m_dir ? lfws_pkg::ACT_BWD : lfws_pkg::ACT_FWD));
    repeat (count) random_beat();
  endtask

  // Corner items under the reset setting and a forward setting.
  task automatic test_directed();
    // Reset setting: speed_max is zero, so ticks are gated off.
    send_beat(lfws_pkg::CMD_TICK, '0);
    send_beat(CMD_UNUSED, '1);
    send_beat(lfws_pkg::CMD_ACT, pack_fields(8'd0, 16'd0, 16'd0, 16'd0, 8'hff));
    load_setting(16'd2000, 16'd4096, 16'd1000, 16'd256, 16'd32767, 16'd0, 1'b0, 16'd127);
    // Direction mismatch: no legal action yet, then a backward one, so ticks stay gated.
    send_beat(lfws_pkg::CMD_TICK, '0);
    send_beat(lfws_pkg::CMD_ACT, pack_fields(8'd0, 16'd0, 16'd0, 16'd0, lfws_pkg::ACT_BWD));
    send_beat(lfws_pkg::CMD_TICK, '0);
    send_beat(lfws_pkg::CMD_ACT, pack_fields(8'd0, 16'd0, 16'd0, 16'd0, lfws_pkg::ACT_FWD));
    // Line good, run zone, then the extremes of lateral.
    send_beat(lfws_pkg::CMD_MEAS, pack_fields(8'h03, 16'd0, 16'd0, 16'h8000, 8'd0));
    repeat (3) send_beat(lfws_pkg::CMD_TICK, '0);
    send_beat(lfws_pkg::CMD_MEAS, pack_fields(8'hff, 16'h7fff, 16'h8000, 16'h8000, 8'd0));
    send_beat(lfws_pkg::CMD_TICK, '0);
    send_beat(lfws_pkg::CMD_MEAS, pack_fields(8'h07, 16'h8000, 16'h0001, 16'h0000, 8'd0));
    send_beat(lfws_pkg::CMD_TICK, '0);
    // Stop zone, then line lost.
    send_beat(lfws_pkg::CMD_MEAS, pack_fields(8'h09, 16'd100, 16'd0, 16'h7fff, 8'd0));
    send_beat(lfws_pkg::CMD_TICK, '0);
    send_beat(lfws_pkg::CMD_MEAS, pack_fields(8'hfe, 16'hff00, 16'd0, 16'hffff, 8'd0));
    send_beat(lfws_pkg::CMD_TICK, '0);
    send_beat(lfws_pkg::CMD_TICK, '1);
  endtask

  // The receiver holds off while ticks keep coming, so the core stalls.
  task automatic test_backpressure();
    drain_core();
    hold_requests++;
    steady = 1'b1;
    repeat (30) send_beat(lfws_pkg::CMD_TICK, pack_fields(8'h03, 16'd0, 16'd0, 16'd0, 8'd0));
    steady = 1'b0;
    // Pause the sender until every queued command has come back.
    drain_core();
  endtask

  task automatic test_random();
    // Forward, moderate gain.
    load_setting(16'd1500, 16'd4096, 16'd1000, 16'd256, 16'd32767, 16'd0, 1'b0, 16'd50);
    random_phase(150);
    // A long stretch with no idling on either side.
    steady = 1'b1;
    random_phase(100);
    steady = 1'b0;
    // Backward at full scale; large gain drives one factor negative.
    load_setting(16'h8000, 16'hffff, 16'd1, 16'hffff, 16'd32767, 16'd100, 1'b1, 16'd100);
    random_phase(200);
    // Zero sensor offset, minimum above maximum.
    load_setting(16'h7fff, 16'd0, 16'd0, 16'd0, 16'd10, 16'd20, 1'b0, 16'd0);
    random_phase(80);
    // Tight clip window, zero offset with gain.
    load_setting(16'h7fff, 16'd12000, 16'd0, 16'd40000, 16'd3000, 16'd500, 1'b0, 16'd35);
    random_phase(120);
    // Random settings, mostly with a consistent direction.
    repeat (3) begin
      logic [15:0] smax;
      logic        dir;
      dir = 1'($urandom_range(0, 1));
      smax = 16'($urandom);
      if ($urandom_range(0, 9) != 0) smax[15] = dir;
      load_setting(smax, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom_range(0, 2000)), dir, 16'($urandom_range(0, 127)));
      random_phase(110);
    end
  endtask

  // Receiver: idles at random, and holds off entirely while hold_left runs.
  always @(negedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(0, 99) >= 34);
    end
  end

  // Checker: each output beat against the oldest queued wheel command.
  always @(posedge clk) begin
    wheel_cmd_t c;
    if (rst_n && out_tvalid && out_tready) begin
      beats_checked++;
      if (wheel_cmds_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected beat: data %h user %b", out_tdata, out_tuser);
      end else begin
        c = wheel_cmds_due.pop_front();
        if (out_tdata[15:0] !== c.left || out_tdata[31:16] !== c.right ||
            out_tuser[0] !== c.lost || out_tuser[1] !== c.trk_low) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: left %h/%h right %h/%h lost %b/%b low %b/%b (exp/act)",
                     c.left, out_tdata[15:0], c.right, out_tdata[31:16],
                     c.lost, out_tuser[0], c.trk_low, out_tuser[1]);
        end
      end
    end
  end

  initial begin
    m_speed_max = 16'sd0; m_gain = 16'd4096; m_offset = 16'd1000; m_scale = 16'd256;
    m_wmax = 15'h7fff; m_wmin = 15'd0; m_dir = 1'b0;
    m_speed_pct = 7'd0; m_target_pct = 7'd0; m_left = 16'd0; m_right = 16'd0;
    m_line_ok = 1'b0; m_level = 3'd0; m_cmd_dir = lfws_pkg::DIR_NONE;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    drain_core();
    if (wheel_cmds_due.size() != 0) fail_count++;
    $display("Sent %0d beats over eight register settings and checked %0d wheel commands,",
             items_sent, beats_checked);
    $display("including a long output stall and gated, lost-line and clipped cases.");
    if (fail_count == 0) begin
      $display("line_follow_wheel_speed_core_test: clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("line_follow_wheel_speed_core_test: errors");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout");
    $display("line_follow_wheel_speed_core_test: errors");
    $finish;
  end

endmodule
`default_nettype wire

// ===== line_follow_wheel_speed_core.f =====
+incdir+src
src/lfws_pkg.sv
src/lfws_ctrl.sv
src/lfws_dp.sv
src/line_follow_wheel_speed_core.sv
src/lfws_checker.sv
bench/line_follow_wheel_speed_core_test.sv
